/* rtl/lmf_pkg.sv */
// Shared types, constants and helper functions for the flanger.
// Holds the sine quarter-wave table builder and 24-bit saturation.
// No dependencies.
package lmf_pkg;

    localparam int DELAY_DEPTH      = 4096;
    localparam int ADDR_W           = $clog2(DELAY_DEPTH);
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int SINE_IDX_W       = $clog2(SINE_TABLE_DEPTH);
    localparam int SINE_QW          = SINE_IDX_W - 2;
    localparam int SINE_Q           = SINE_TABLE_DEPTH / 4;

    localparam int SAMPLE_W = 24;
    localparam int LFO_W    = 18;
    localparam int CFG_W    = 24;
    localparam int SAT_W    = 48;
    localparam int FRAC_W   = 8;
    localparam int DLY_W    = ADDR_W + FRAC_W;
    localparam int DSUM_W   = (DLY_W > 22) ? DLY_W : 22;
    localparam int DLY_CAP  = (DELAY_DEPTH - 1) * 256;
    localparam int ONE_Q16  = 65536;

    localparam logic [19:0] BASE_DELAY_RST = 20'd12288;
    localparam logic [19:0] DEPTH_DELAY_RST = 20'd24576;
    localparam logic [15:0] FEEDBACK_RST   = 16'd0;
    localparam logic [16:0] WET_MIX_RST    = 17'd32768;
    localparam logic [23:0] PHASE_STEP_RST = 24'd44739;

    typedef enum logic [2:0] {
        CFG_BASE_DELAY  = 3'd0,
        CFG_DEPTH_DELAY = 3'd1,
        CFG_FEEDBACK    = 3'd2,
        CFG_WET_MIX     = 3'd3,
        CFG_PHASE_STEP  = 3'd4,
        CFG_LFO_SHAPE   = 3'd5,
        CFG_INVERT_WET  = 3'd6
    } cfg_idx_e;

    typedef enum logic [1:0] {
        LFO_SINE     = 2'd0,
        LFO_TRIANGLE = 2'd1,
        LFO_SAWTOOTH = 2'd2,
        LFO_SQUARE   = 2'd3
    } lfo_shape_e;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADDR,
        ST_RD_N,
        ST_RD_O,
        ST_CAP,
        ST_INT,
        ST_PROD,
        ST_FIN
    } state_t;

    typedef struct packed {
        logic                we;
        logic [ADDR_W-1:0]   addr;
        logic [SAMPLE_W-1:0] data;
    } mem_wr_t;

    typedef logic [16:0] sine_tab_t [SINE_Q+1];

    function automatic sine_tab_t build_sine();
        sine_tab_t tab;
        longint    x;
        longint    x2;
        longint    s;
        for (int j = 0; j <= SINE_Q; j++)
        begin
            x  = longint'(j) * (longint'(1) << (16 - SINE_QW));
            x2 = (x * x) >> 16;
            s  = (x * (102944 - ((x2 * (42334 - ((x2 * 4926) >> 16))) >> 16))) >> 16;
            if (s > ONE_Q16)
            begin
                s = ONE_Q16;
            end
            tab[j] = 17'(s);
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine();

    function automatic logic signed [SAMPLE_W-1:0] sat24(input logic signed [SAT_W-1:0] v);
        logic signed [SAMPLE_W-1:0] r;
        if (v > 48'sd8388607)
        begin
            r = 24'sh7FFFFF;
        end
        else if (v < -48'sd8388608)
        begin
            r = 24'sh800000;
        end
        else
        begin
            r = v[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

/* rtl/lmf_lfo.sv */
// LFO phase accumulator and waveform generator (sine, triangle, saw, square).
// Depends on lmf_pkg for the quarter-wave sine table and shape codes.
module lmf_lfo
    import lmf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [23:0]             phase_step,
    input  logic [1:0]              shape,
    input  logic                    advance,
    output logic signed [LFO_W-1:0] lfo
);

    logic [31:0]             phase_reg;
    logic [31:0]             phase_next;
    logic signed [LFO_W-1:0] lfo_reg;
    logic signed [LFO_W-1:0] lfo_next;

    logic [SINE_IDX_W-1:0] idx;
    logic [1:0]            quad;
    logic [SINE_QW-1:0]    k;
    logic [SINE_QW:0]      j;
    logic [16:0]           s;
    logic [15:0]           p;
    logic [15:0]           d;

    always_comb
    begin
        phase_next = advance ? (phase_reg + {8'd0, phase_step}) : phase_reg;

        idx  = phase_reg[31 -: SINE_IDX_W];
        quad = idx[SINE_IDX_W-1 -: 2];
        k    = idx[SINE_QW-1:0];
        j    = quad[0] ? ((SINE_QW+1)'(SINE_Q) - {1'b0, k}) : {1'b0, k};
        s    = SINE_TAB[j];

        p = phase_reg[31:16];
        d = p[15] ? {1'b0, p[14:0]} : (16'd32768 - p);

        case (lfo_shape_e'(shape))
            LFO_SINE:     lfo_next = quad[1] ? -$signed({1'b0, s}) : $signed({1'b0, s});
            LFO_TRIANGLE: lfo_next = $signed(18'd65536 - {d, 2'b00});
            LFO_SAWTOOTH: lfo_next = $signed({1'b0, p, 1'b0} - 18'd65536);
            LFO_SQUARE:   lfo_next = p[15] ? -18'sd65536 : 18'sd65536;
            default:      lfo_next = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            lfo_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            lfo_reg   <= lfo_next;
        end
    end

    assign lfo = lfo_reg;

endmodule

/* rtl/lmf_dly_mem.sv */
// Delay line store: one write port, one read port, registered read data.
// Depends on lmf_pkg for depth, widths and the write request struct.
module lmf_dly_mem
    import lmf_pkg::*;
(
    input  logic                clk,
    input  mem_wr_t             wr,
    input  logic [ADDR_W-1:0]   rd_addr,
    output logic [SAMPLE_W-1:0] rd_data
);

    logic [SAMPLE_W-1:0] mem [DELAY_DEPTH];
    logic [SAMPLE_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/lfo_modulated_flanger_top.sv */
// Flanger top level: configuration registers, sequencer and sample datapath.
// Depends on lmf_pkg, lmf_lfo and lmf_dly_mem.
//
// Each accepted word is carried through the sequencer before the next word
// can be taken: the sequencer steps through the delay product, tap addressing,
// two reads of the single read port of the 4096-entry delay store, interpolation,
// the gain products and the write-back of the feedback sample. A finished word
// waits in the output register, so a new word is accepted while it is stalled.
// Store entries not yet written since reset read as zero, tracked by the write
// index and a wrap flag, so no clearing pass runs after reset.
module lfo_modulated_flanger_top
    import lmf_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [SAMPLE_W-1:0] sample_out,
    input  logic                       cfg_we,
    input  logic [2:0]                 cfg_index,
    input  logic [CFG_W-1:0]           cfg_data
);

    logic [19:0] base_reg;
    logic [19:0] depth_reg;
    logic [15:0] fb_reg;
    logic [16:0] wet_mix_reg;
    logic [23:0] step_reg;
    logic [1:0]  shape_reg;
    logic        invert_reg;

    state_t state_reg;
    state_t state_next;

    logic [ADDR_W-1:0] w_reg;
    logic              wrapped_reg;
    logic              out_valid_reg;
    logic signed [SAMPLE_W-1:0] sample_out_reg;

    logic signed [SAMPLE_W-1:0] x_reg;
    logic [36:0]                prod_reg;
    logic [ADDR_W-1:0]          ip_reg;
    logic [FRAC_W-1:0]          fr_reg;
    logic [ADDR_W-1:0]          tap_addr_reg;
    logic signed [SAMPLE_W-1:0] n_reg;
    logic signed [SAMPLE_W-1:0] o_reg;
    logic signed [24:0]         wet_reg;
    logic signed [41:0]         fb_p_reg;
    logic signed [42:0]         dry_p_reg;
    logic signed [42:0]         wet_p_reg;

    logic signed [LFO_W-1:0] lfo;
    logic                    fin_go;
    logic [18:0]             lfo_off;
    logic [16:0]             u;
    logic [DSUM_W-1:0]       dly_sum;
    logic [DLY_W-1:0]        dly;
    logic [ADDR_W-1:0]       newer;
    logic [ADDR_W-1:0]       older;
    logic [ADDR_W-1:0]       rd_addr;
    logic [SAMPLE_W-1:0]     rd_data;
    logic signed [SAMPLE_W-1:0] tap;
    logic signed [9:0]       wn_s;
    logic signed [9:0]       wf_s;
    logic signed [33:0]      interp;
    logic signed [SAMPLE_W-1:0] delayed;
    logic [16:0]             m;
    logic signed [17:0]      m_s;
    logic signed [17:0]      dm_s;
    logic signed [16:0]      fb_s;
    logic signed [25:0]      fb_sh;
    logic signed [26:0]      wsum;
    logic signed [43:0]      mix_sum;
    logic signed [27:0]      y_sh;
    logic signed [SAMPLE_W-1:0] wsat;
    logic signed [SAMPLE_W-1:0] ysat;
    mem_wr_t                 mem_wr;

    lmf_lfo u_lfo
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .phase_step (step_reg),
        .shape      (shape_reg),
        .advance    (fin_go),
        .lfo        (lfo)
    );

    lmf_dly_mem u_mem
    (
        .clk     (clk),
        .wr      (mem_wr),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg    <= BASE_DELAY_RST;
            depth_reg   <= DEPTH_DELAY_RST;
            fb_reg      <= FEEDBACK_RST;
            wet_mix_reg <= WET_MIX_RST;
            step_reg    <= PHASE_STEP_RST;
            shape_reg   <= LFO_SINE;
            invert_reg  <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_e'(cfg_index))
                CFG_BASE_DELAY:  base_reg    <= cfg_data[19:0];
                CFG_DEPTH_DELAY: depth_reg   <= cfg_data[19:0];
                CFG_FEEDBACK:    fb_reg      <= cfg_data[15:0];
                CFG_WET_MIX:     wet_mix_reg <= cfg_data[16:0];
                CFG_PHASE_STEP:  step_reg    <= cfg_data[23:0];
                CFG_LFO_SHAPE:   shape_reg   <= cfg_data[1:0];
                CFG_INVERT_WET:  invert_reg  <= cfg_data[0];
                default:         ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        fin_go     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_ADDR;
            ST_ADDR: state_next = ST_RD_N;
            ST_RD_N: state_next = ST_RD_O;
            ST_RD_O: state_next = ST_CAP;
            ST_CAP:  state_next = ST_INT;
            ST_INT:  state_next = ST_PROD;
            ST_PROD: state_next = ST_FIN;
            ST_FIN:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    fin_go     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath arithmetic
    always_comb
    begin
        lfo_off = {lfo[LFO_W-1], lfo} + 19'd65536;
        u       = lfo_off[17:1];

        dly_sum = DSUM_W'(base_reg) + DSUM_W'(prod_reg[36:16]);
        dly     = (dly_sum > DSUM_W'(DLY_CAP)) ? DLY_W'(DLY_CAP) : dly_sum[DLY_W-1:0];

        newer   = w_reg - ip_reg;
        older   = w_reg - ip_reg - ADDR_W'(1);
        rd_addr = (state_reg == ST_RD_N) ? newer : older;

        // the slot being written this step holds the input; unwritten slots read as zero
        if (tap_addr_reg == w_reg)
        begin
            tap = x_reg;
        end
        else if (wrapped_reg || (tap_addr_reg < w_reg))
        begin
            tap = $signed(rd_data);
        end
        else
        begin
            tap = '0;
        end

        wn_s    = $signed({1'b0, 9'd256 - {1'b0, fr_reg}});
        wf_s    = $signed({2'b00, fr_reg});
        interp  = n_reg * wn_s + o_reg * wf_s;
        delayed = interp[31:8];

        m    = (wet_mix_reg > 17'd65536) ? 17'd65536 : wet_mix_reg;
        m_s  = $signed({1'b0, m});
        dm_s = $signed({1'b0, 17'd65536 - m});
        fb_s = $signed({1'b0, fb_reg});

        fb_sh   = fb_p_reg[41:16];
        wsum    = {{3{x_reg[SAMPLE_W-1]}}, x_reg} + {fb_sh[25], fb_sh};
        mix_sum = {dry_p_reg[42], dry_p_reg} + {wet_p_reg[42], wet_p_reg};
        y_sh    = mix_sum[43:16];
        wsat    = sat24({{(SAT_W-27){wsum[26]}}, wsum});
        ysat    = sat24({{(SAT_W-28){y_sh[27]}}, y_sh});

        mem_wr.we   = fin_go;
        mem_wr.addr = w_reg;
        mem_wr.data = wsat;
    end

    always_ff @(posedge clk)
    begin
        tap_addr_reg <= rd_addr;
        if ((state_reg == ST_IDLE) && in_valid)
        begin
            x_reg <= sample_in;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= depth_reg * u;
        end
        if (state_reg == ST_ADDR)
        begin
            ip_reg <= dly[DLY_W-1:FRAC_W];
            fr_reg <= dly[FRAC_W-1:0];
        end
        if (state_reg == ST_RD_O)
        begin
            n_reg <= tap;
        end
        if (state_reg == ST_CAP)
        begin
            o_reg <= tap;
        end
        if (state_reg == ST_INT)
        begin
            wet_reg <= invert_reg ? -{delayed[SAMPLE_W-1], delayed}
                                  : {delayed[SAMPLE_W-1], delayed};
        end
        if (state_reg == ST_PROD)
        begin
            fb_p_reg  <= wet_reg * fb_s;
            dry_p_reg <= x_reg * dm_s;
            wet_p_reg <= wet_reg * m_s;
        end
        if (fin_go)
        begin
            sample_out_reg <= ysat;
        end
    end

    // write index, wrap flag and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg         <= '0;
            wrapped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (fin_go)
            begin
                w_reg <= w_reg + ADDR_W'(1);
                if (w_reg == {ADDR_W{1'b1}})
                begin
                    wrapped_reg <= 1'b1;
                end
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;

endmodule

/* sim/lfo_modulated_flanger_top_test.sv */
`timescale 1ns / 1ps
// Self-checking bench for lfo_modulated_flanger_top: a word driver, a result monitor
// and a behavioural flanger predictor kept in step with the configuration port.
// Depends on lmf_pkg and the flanger RTL.
module lfo_modulated_flanger_top_test;
    import lmf_pkg::*;

    localparam int     LIMIT  = 400000;
    localparam longint S24_HI = 8388607;
    localparam longint S24_LO = -8388608;

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       cfg_we = 1'b0;
    logic [2:0]                 cfg_index = '0;
    logic [CFG_W-1:0]           cfg_data = '0;

    // flanger state and settings as the predictor sees them
    logic signed [SAMPLE_W-1:0] tap_mem [DELAY_DEPTH];
    logic [ADDR_W-1:0]          wr_ptr;
    logic [31:0]                lfo_acc;
    logic [19:0]                base_dly;
    logic [19:0]                depth_dly;
    logic [15:0]                fb_gain;
    logic [16:0]                wet_share;
    logic [23:0]                phase_step;
    lfo_shape_e                 shape;
    logic                       inv_wet;

    logic signed [SAMPLE_W-1:0] pend_words [$];
    logic signed [SAMPLE_W-1:0] expected_out [$];
    logic signed [SAMPLE_W-1:0] want;
    int                         pushed = 0;
    int                         accepted = 0;
    int                         errors = 0;
    int                         cycles = 0;
    int                         gap_left = 0;
    int                         stall_left = 0;
    int unsigned                idle_pct = 0;

    lfo_modulated_flanger_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .sample_in  (sample_in),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .sample_out (sample_out),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic longint clip24(longint v);
        longint r;
        r = v;
        if (v > S24_HI)
        begin
            r = S24_HI;
        end
        else if (v < S24_LO)
        begin
            r = S24_LO;
        end
        return r;
    endfunction

    function automatic longint lfo_level();
        longint     p;
        longint     r;
        longint     xq;
        longint     x2;
        longint     lv;
        logic [7:0] ang;
        p   = longint'(lfo_acc[31:16]);
        ang = lfo_acc[31:24];
        case (shape)
            LFO_TRIANGLE: lv = 65536 - 4 * ((p >= 32768) ? p - 32768 : 32768 - p);
            LFO_SAWTOOTH: lv = 2 * p - 65536;
            LFO_SQUARE:   lv = (p < 32768) ? 65536 : -65536;
            default:
            begin
                r = longint'(ang[5:0]) << 24;
                if (ang[6])
                begin
                    r = (longint'(1) << 30) - r;
                end
                xq = r >> 14;
                x2 = (xq * xq) >> 16;
                lv = (xq * (102944 - ((x2 * (42334 - ((x2 * 4926) >> 16))) >> 16))) >> 16;
                if (lv > 65536)
                begin
                    lv = 65536;
                end
                if (ang[7])
                begin
                    lv = -lv;
                end
            end
        endcase
        return lv;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] flanger_sample(
        logic signed [SAMPLE_W-1:0] x);
        longint            u;
        longint            dly;
        longint            fr;
        longint            mix;
        longint            dlyd;
        longint            wet;
        longint            y;
        logic [ADDR_W-1:0] ip;
        logic [ADDR_W-1:0] newer;
        logic [ADDR_W-1:0] older;
        tap_mem[wr_ptr] = x;
        u   = (lfo_level() + 65536) >>> 1;
        dly = longint'(base_dly) + ((longint'(depth_dly) * u) >>> 16);
        if (dly > DLY_CAP)
        begin
            dly = DLY_CAP;
        end
        ip    = ADDR_W'(dly >>> 8);
        fr    = dly & 255;
        newer = wr_ptr - ip;
        older = wr_ptr - ip - 1'b1;
        dlyd  = (longint'(tap_mem[newer]) * (256 - fr) + longint'(tap_mem[older]) * fr) >>> 8;
        wet   = inv_wet ? -dlyd : dlyd;
        tap_mem[wr_ptr] = SAMPLE_W'(clip24(longint'(x) + ((wet * longint'(fb_gain)) >>> 16)));
        mix = (wet_share > 17'd65536) ? 65536 : longint'(wet_share);
        y   = clip24((longint'(x) * (65536 - mix) + wet * mix) >>> 16);
        wr_ptr  = wr_ptr + 1'b1;
        lfo_acc = lfo_acc + 32'(phase_step);
        return SAMPLE_W'(y);
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] rand_word();
        logic signed [SAMPLE_W-1:0] w;
        case ($urandom_range(0, 9))
            0:       w = 24'sh7FFFFF;
            1:       w = 24'sh800000;
            2, 3:    w = SAMPLE_W'($urandom_range(0, 4095)) - 24'sd2048;
            default: w = SAMPLE_W'($urandom);
        endcase
        return w;
    endfunction

    function automatic logic [CFG_W-1:0] pick(logic [CFG_W-1:0] top, int unsigned typ);
        logic [CFG_W-1:0] v;
        case ($urandom_range(0, 5))
            0:       v = '0;
            1:       v = top;
            default: v = CFG_W'($urandom_range(0, typ));
        endcase
        return v;
    endfunction

    task automatic write_reg(cfg_idx_e idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            CFG_BASE_DELAY:  base_dly   = val[19:0];
            CFG_DEPTH_DELAY: depth_dly  = val[19:0];
            CFG_FEEDBACK:    fb_gain    = val[15:0];
            CFG_WET_MIX:     wet_share  = val[16:0];
            CFG_PHASE_STEP:  phase_step = val[23:0];
            CFG_LFO_SHAPE:   shape      = lfo_shape_e'(val[1:0]);
            CFG_INVERT_WET:  inv_wet    = val[0];
            default: ;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send(logic signed [SAMPLE_W-1:0] w);
        pend_words.push_back(w);
        pushed++;
    endtask

    task automatic settle();
        while (accepted != pushed || expected_out.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (20) @(posedge clk);
    endtask

    task automatic random_setting(int k);
        write_reg(CFG_BASE_DELAY, pick(24'hFFFFF, 64 * 256));
        write_reg(CFG_DEPTH_DELAY, (k == 4) ? CFG_W'($urandom_range(256, 64 * 256))
                                            : pick(24'hFFFFF, 64 * 256));
        write_reg(CFG_FEEDBACK, pick(24'hFFFF, 65535));
        write_reg(CFG_WET_MIX, pick(24'h1FFFF, 65536));
        write_reg(CFG_PHASE_STEP, (k == 4) ? 24'hFFFFFF : pick(24'hFFFFFF, 24'hFFFFFF));
        write_reg(CFG_LFO_SHAPE, CFG_W'(k % 4));
        write_reg(CFG_INVERT_WET, CFG_W'($urandom_range(0, 1)));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            sample_in <= '0;
            gap_left   = 0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                expected_out.push_back(flanger_sample(sample_in));
                accepted++;
            end
            // hold the word while stalled
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (pend_words.size() != 0 && idle_pct != 0
                         && $urandom_range(0, 99) < idle_pct)
                begin
                    gap_left = $urandom_range(0, 14);
                    in_valid <= 1'b0;
                end
                else if (pend_words.size() != 0)
                begin
                    in_valid  <= 1'b1;
                    sample_in <= pend_words.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_out.size() == 0)
                begin
                    errors++;
                    $display("%0t: sample_out expected none, actual %0d", $time, sample_out);
                end
                else
                begin
                    want = expected_out.pop_front();
                    if (sample_out !== want)
                    begin
                        errors++;
                        $display("%0t: sample_out expected %0d, actual %0d",
                                 $time, want, sample_out);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
            begin
                stall_left = $urandom_range(0, 14);
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("lfo_modulated_flanger_top_test NOT OK");
            $finish;
        end
    end

    initial
    begin
        int n;
        rst_n = 1'b0;
        foreach (tap_mem[i])
        begin
            tap_mem[i] = '0;
        end
        wr_ptr     = '0;
        lfo_acc    = '0;
        base_dly   = BASE_DELAY_RST;
        depth_dly  = DEPTH_DELAY_RST;
        fb_gain    = FEEDBACK_RST;
        wet_share  = WET_MIX_RST;
        phase_step = PHASE_STEP_RST;
        shape      = LFO_SINE;
        inv_wet    = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 15;
        send(24'sh7FFFFF);
        send(24'sh800000);
        send(24'sh000000);
        send(24'shFFFFFF);
        send(24'sh000001);
        send(24'sh555555);
        send(24'shAAAAAA);
        settle();

        // zero delay: the newer tap is the word just written
        write_reg(CFG_BASE_DELAY, 24'd0);
        write_reg(CFG_DEPTH_DELAY, 24'd0);
        write_reg(CFG_FEEDBACK, 24'd64880);
        write_reg(CFG_WET_MIX, 24'd65536);
        write_reg(CFG_LFO_SHAPE, CFG_W'(LFO_SQUARE));
        write_reg(CFG_INVERT_WET, 24'd1);
        send(24'sh7FFFFF);
        send(24'sh7FFFFF);
        send(24'sh800000);
        send(24'sh800000);
        settle();

        // delay past the end of the store, mix above full scale
        write_reg(CFG_BASE_DELAY, 24'hFFFFF);
        write_reg(CFG_DEPTH_DELAY, 24'hFFFFF);
        write_reg(CFG_FEEDBACK, 24'hFFFF);
        write_reg(CFG_WET_MIX, 24'h1FFFF);
        write_reg(CFG_LFO_SHAPE, CFG_W'(LFO_TRIANGLE));
        write_reg(CFG_INVERT_WET, 24'd0);
        send(24'sh400000);
        send(24'shC00000);
        send(24'sh7FFFFF);
        settle();

        write_reg(CFG_PHASE_STEP, 24'hFFFFFF);
        write_reg(CFG_LFO_SHAPE, CFG_W'(LFO_SAWTOOTH));
        write_reg(CFG_WET_MIX, 24'd0);
        write_reg(CFG_BASE_DELAY, 24'd896);
        write_reg(CFG_DEPTH_DELAY, 24'd2048);
        write_reg(CFG_FEEDBACK, 24'd0);
        send(24'sh7FFFFF);
        send(24'sh800000);
        send(24'sh123456);
        send(24'shEDCBA9);
        send(24'sh7FFFFF);
        send(24'sh800000);
        settle();

        for (int k = 0; k < 9; k++)
        begin
            random_setting(k);
            case (k % 3)
                0:       idle_pct = 0;
                1:       idle_pct = 8;
                default: idle_pct = 35;
            endcase
            if (k == 8)
            begin
                idle_pct = 0;
            end
            n = (k == 4) ? 260 : $urandom_range(40, 90);
            repeat (n) send(rand_word());
            settle();
        end

        if (errors == 0)
        begin
            $display("lfo_modulated_flanger_top_test OK");
        end
        else
        begin
            $display("lfo_modulated_flanger_top_test NOT OK");
        end
        $finish;
    end

endmodule

/* lfo_modulated_flanger_top.f */
rtl/lmf_pkg.sv
rtl/lmf_lfo.sv
rtl/lmf_dly_mem.sv
rtl/lfo_modulated_flanger_top.sv
sim/lfo_modulated_flanger_top_test.sv
